>>> rtl/sync_word_packet_deframer_defines.svh
// assertion macros for the sync word packet deframer
`ifndef SYNC_WORD_PACKET_DEFRAMER_DEFINES_SVH
`define SYNC_WORD_PACKET_DEFRAMER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SWPD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("swpd assertion failed");

// next-cycle implication, checked out of reset
`define SWPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("swpd assertion failed");

`endif

>>> rtl/swpd_pkg.sv
// shared types and constants of the sync word packet deframer
`default_nettype none
package swpd_pkg;

  localparam logic [7:0]  START_FIRST      = 8'h6E;
  localparam logic [7:0]  START_SECOND     = 8'h40;
  localparam logic [15:0] MAX_LENGTH_RESET = 16'd2000;

  localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
  localparam logic [1:0] KIND_GOOD      = 2'd1;
  localparam logic [1:0] KIND_BAD       = 2'd2;
  localparam logic [1:0] KIND_REJECTED  = 2'd3;

  localparam logic [0:0] REG_MAX_LENGTH   = 1'd0;
  localparam logic [0:0] REG_CHECK_ENABLE = 1'd1;

  typedef struct packed {
    logic [15:0] max_length;
    logic        check_enable;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [7:0]  packet_type;
    logic [7:0]  packet_counter;
    logic [15:0] payload_length;
    logic        last;
  } res_t;

endpackage
`default_nettype wire

>>> rtl/swpd_cfg.sv
// configuration registers behind the apb port
`default_nettype none
module swpd_cfg
  import swpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output cfg_t             cfg
);

  logic [15:0] max_length;
  logic        check_enable;
  logic        wr;
  logic [0:0]  reg_index;

  assign wr        = psel && penable && pwrite;
  assign reg_index = paddr[2:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length   <= MAX_LENGTH_RESET;
      check_enable <= 1'b1;
    end else if (wr) begin
      case (reg_index)
        REG_MAX_LENGTH:   max_length   <= pwdata[15:0];
        REG_CHECK_ENABLE: check_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_MAX_LENGTH:   prdata = {16'd0, max_length};
      REG_CHECK_ENABLE: prdata = {31'd0, check_enable};
      default:          prdata = 32'd0;
    endcase
  end

  assign cfg.max_length   = max_length;
  assign cfg.check_enable = check_enable;

endmodule
`default_nettype wire

>>> rtl/swpd_parse.sv
// frame state machine: sync hunt, header, payload count and fletcher-style check with sums modulo 256
`default_nettype none
module swpd_parse
  import swpd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] in_byte,
  input  wire cfg_t       cfg,
  output logic            res_valid,
  output res_t            res
);

  localparam logic [2:0] PH_HUNT0  = 3'd0;
  localparam logic [2:0] PH_HUNT1  = 3'd1;
  localparam logic [2:0] PH_HEADER = 3'd2;
  localparam logic [2:0] PH_DATA   = 3'd3;
  localparam logic [2:0] PH_CHECK  = 3'd4;

  logic [2:0]  phase, phase_next;
  logic [1:0]  header_index, header_index_next;
  logic [7:0]  type_reg, type_reg_next;
  logic [7:0]  counter_reg, counter_reg_next;
  logic [15:0] length_reg, length_reg_next;
  logic [15:0] bytes_seen, bytes_seen_next;
  logic [7:0]  sum_a, sum_a_next;
  logic [7:0]  sum_b, sum_b_next;
  logic [7:0]  check_high, check_high_next;

  logic [7:0]  acc_a;
  logic [7:0]  acc_b;
  logic [15:0] seen_inc;
  logic        check_ok;

  assign acc_a    = sum_a + in_byte;
  assign acc_b    = sum_b + acc_a;
  assign seen_inc = bytes_seen + 16'd1;
  assign check_ok = !cfg.check_enable || ({check_high, in_byte} == {sum_a, sum_b});

  always_comb begin
    phase_next        = phase;
    header_index_next = header_index;
    type_reg_next     = type_reg;
    counter_reg_next  = counter_reg;
    length_reg_next   = length_reg;
    bytes_seen_next   = bytes_seen;
    sum_a_next        = sum_a;
    sum_b_next        = sum_b;
    check_high_next   = check_high;
    res_valid         = 1'b0;
    res.kind          = KIND_PAYLOAD;
    res.data_byte     = 8'd0;
    res.last          = 1'b0;

    case (phase)
      PH_HUNT1: begin
        if (in_byte == START_SECOND) begin
          phase_next        = PH_HEADER;
          header_index_next = 2'd0;
          type_reg_next     = 8'd0;
          counter_reg_next  = 8'd0;
          length_reg_next   = 16'd0;
          bytes_seen_next   = 16'd0;
          sum_a_next        = 8'd0;
          sum_b_next        = 8'd0;
          check_high_next   = 8'd0;
        end else begin
          phase_next = PH_HUNT0;
        end
      end
      PH_HEADER: begin
        sum_a_next = acc_a;
        sum_b_next = acc_b;
        case (header_index)
          2'd0: begin
            type_reg_next     = in_byte;
            header_index_next = 2'd1;
          end
          2'd1: begin
            counter_reg_next  = in_byte;
            header_index_next = 2'd2;
          end
          2'd2: begin
            length_reg_next   = {in_byte, 8'd0};
            header_index_next = 2'd3;
          end
          default: begin
            length_reg_next   = {length_reg[15:8], in_byte};
            header_index_next = 2'd0;
            bytes_seen_next   = 16'd0;
            if ({length_reg[15:8], in_byte} > cfg.max_length) begin
              phase_next = PH_HUNT0;
              res_valid  = 1'b1;
              res.kind   = KIND_REJECTED;
              res.last   = 1'b1;
            end else if ({length_reg[15:8], in_byte} == 16'd0) begin
              phase_next = PH_CHECK;
            end else begin
              phase_next = PH_DATA;
            end
          end
        endcase
      end
      PH_DATA: begin
        sum_a_next      = acc_a;
        sum_b_next      = acc_b;
        bytes_seen_next = seen_inc;
        if (seen_inc == length_reg) begin
          phase_next        = PH_CHECK;
          header_index_next = 2'd0;
        end
        res_valid     = 1'b1;
        res.kind      = KIND_PAYLOAD;
        res.data_byte = in_byte;
      end
      PH_CHECK: begin
        if (header_index == 2'd0) begin
          check_high_next   = in_byte;
          header_index_next = 2'd1;
        end else begin
          // high check byte came first, this is the low one
          header_index_next = 2'd0;
          phase_next        = PH_HUNT0;
          res_valid         = 1'b1;
          res.kind          = check_ok ? KIND_GOOD : KIND_BAD;
          res.last          = 1'b1;
        end
      end
      default: begin
        phase_next = (in_byte == START_FIRST) ? PH_HUNT1 : PH_HUNT0;
      end
    endcase

    // header fields as they stand after this item
    res.packet_type    = type_reg_next;
    res.packet_counter = counter_reg_next;
    res.payload_length = length_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT0;
      header_index <= 2'd0;
      type_reg     <= 8'd0;
      counter_reg  <= 8'd0;
      length_reg   <= 16'd0;
      bytes_seen   <= 16'd0;
      sum_a        <= 8'd0;
      sum_b        <= 8'd0;
      check_high   <= 8'd0;
    end else if (step) begin
      phase        <= phase_next;
      header_index <= header_index_next;
      type_reg     <= type_reg_next;
      counter_reg  <= counter_reg_next;
      length_reg   <= length_reg_next;
      bytes_seen   <= bytes_seen_next;
      sum_a        <= sum_a_next;
      sum_b        <= sum_b_next;
      check_high   <= check_high_next;
    end
  end

endmodule
`default_nettype wire

>>> rtl/swpd_out.sv
// result register driving the master stream
`default_nettype none
module swpd_out
  import swpd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   load,
  input  wire res_t   res,
  output logic        m_axis_tvalid,
  input  wire logic   m_axis_tready,
  output logic [39:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  res_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign m_axis_tdata = {held.payload_length, held.packet_counter, held.packet_type,
                         held.data_byte};
  assign m_axis_tuser = held.kind;
  assign m_axis_tlast = held.last;

endmodule
`default_nettype wire

>>> rtl/sync_word_packet_deframer.sv
// a taken item is held in in_byte; its result is registered on the master side as it moves on
// throughput: one item per cycle unless the master side stalls, set by the frame state update
// while a result waits on the master side, one more item is held and s_axis_tready drops
// reset (rst, synchronous): hunt for the first start byte, sums and header cleared,
// max_length 2000, check_enable 1
`default_nettype none
`include "sync_word_packet_deframer_defines.svh"
module sync_word_packet_deframer
  import swpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // in_byte[7:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // data_byte[7:0], packet_type[15:8],
                                          // packet_counter[23:16], payload_length[39:24]
  output logic [1:0]       m_axis_tuser,  // kind[1:0]
  output logic             m_axis_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t       cfg;
  res_t       res;
  logic       res_valid;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;

  assign pready = 1'b1;

  // an item moves on when the result register has room for it
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  swpd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  swpd_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .in_byte   (in_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  swpd_out u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (advance && res_valid),
    .res           (res),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  `SWPD_ASSERT_NEXT(a_in_held, clk, rst, in_valid && !advance, in_valid)
  `SWPD_ASSERT_NOW(a_no_overwrite, clk, rst, s_axis_tvalid && s_axis_tready && in_valid,
                   advance)
  `SWPD_ASSERT_NEXT(a_result_shown, clk, rst, advance && res_valid, m_axis_tvalid)

endmodule
`default_nettype wire

>>> tb/sv/tb_sync_word_packet_deframer.sv
// self-checking testbench for the sync word packet deframer
module tb_sync_word_packet_deframer;
  import swpd_pkg::*;

  typedef enum logic [2:0] {
    ST_HUNT_FIRST,
    ST_HUNT_SECOND,
    ST_HEADER,
    ST_PAYLOAD,
    ST_CHECK
  } frame_state_e;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // in_byte[7:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;           // data_byte, packet_type, packet_counter, payload_length
  logic [1:0]  m_axis_tuser;           // kind[1:0]
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  sync_word_packet_deframer dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // deframer state as the block should hold it
  frame_state_e fr_state;
  logic [1:0]   hdr_idx;
  logic [7:0]   hdr_type;
  logic [7:0]   hdr_counter;
  logic [15:0]  hdr_length;
  logic [15:0]  payload_count;
  logic [7:0]   run_a;
  logic [7:0]   run_b;
  logic [7:0]   check_msb;
  logic [15:0]  cfg_max_length;
  logic         cfg_check_enable;
  res_t         expected_results[$];

  logic [7:0]   pending_bytes[$];
  logic         byte_taken = 1'b0;
  int           send_idle_pct = 0;
  int           stall_pct = 0;
  logic [15:0]  stim_max_length;

  int errors = 0;
  int bytes_accepted = 0;
  int settings_used = 1;
  int n_payload = 0;
  int n_good = 0;
  int n_bad = 0;
  int n_rejected = 0;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    if (errors <= 40) begin
      $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    end
  endtask

  task automatic push_result(input logic [1:0] k, input logic [7:0] d, input logic l);
    res_t r;
    r.kind = k;
    r.data_byte = d;
    r.packet_type = hdr_type;
    r.packet_counter = hdr_counter;
    r.payload_length = hdr_length;
    r.last = l;
    expected_results = {expected_results, r};
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic [15:0] got_check;
    case (fr_state)
      ST_HUNT_SECOND: begin
        if (b == START_SECOND) begin
          fr_state = ST_HEADER;
          hdr_idx = 2'd0;
          hdr_type = 8'h00;
          hdr_counter = 8'h00;
          hdr_length = 16'h0000;
          payload_count = 16'h0000;
          run_a = 8'h00;
          run_b = 8'h00;
          check_msb = 8'h00;
        end else begin
          // a wrong second start byte is swallowed, even another first byte
          fr_state = ST_HUNT_FIRST;
        end
      end
      ST_HEADER: begin
        run_a = run_a + b;
        run_b = run_b + run_a;
        case (hdr_idx)
          2'd0: begin
            hdr_type = b;
            hdr_idx = 2'd1;
          end
          2'd1: begin
            hdr_counter = b;
            hdr_idx = 2'd2;
          end
          2'd2: begin
            hdr_length = {b, 8'h00};
            hdr_idx = 2'd3;
          end
          default: begin
            hdr_length[7:0] = b;
            hdr_idx = 2'd0;
            payload_count = 16'h0000;
            if (hdr_length > cfg_max_length) begin
              fr_state = ST_HUNT_FIRST;
              push_result(KIND_REJECTED, 8'h00, 1'b1);
            end else begin
              fr_state = (hdr_length == 16'h0000) ? ST_CHECK : ST_PAYLOAD;
            end
          end
        endcase
      end
      ST_PAYLOAD: begin
        run_a = run_a + b;
        run_b = run_b + run_a;
        payload_count = payload_count + 16'd1;
        if (payload_count == hdr_length) begin
          fr_state = ST_CHECK;
          hdr_idx = 2'd0;
        end
        push_result(KIND_PAYLOAD, b, 1'b0);
      end
      ST_CHECK: begin
        if (hdr_idx == 2'd0) begin
          check_msb = b;
          hdr_idx = 2'd1;
        end else begin
          hdr_idx = 2'd0;
          fr_state = ST_HUNT_FIRST;
          got_check = {check_msb, b};
          if (!cfg_check_enable || got_check == {run_a, run_b}) begin
            push_result(KIND_GOOD, 8'h00, 1'b1);
          end else begin
            push_result(KIND_BAD, 8'h00, 1'b1);
          end
        end
      end
      default: begin
        fr_state = (b == START_FIRST) ? ST_HUNT_SECOND : ST_HUNT_FIRST;
      end
    endcase
  endtask

  task automatic check_result();
    res_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with nothing expected", m_axis_tdata, 0);
    end else begin
      want = expected_results.pop_front();
      case (want.kind)
        KIND_PAYLOAD: n_payload++;
        KIND_GOOD: n_good++;
        KIND_BAD: n_bad++;
        default: n_rejected++;
      endcase
      if (m_axis_tuser !== want.kind) report_mismatch("kind", m_axis_tuser, want.kind);
      if (m_axis_tdata[7:0] !== want.data_byte)
        report_mismatch("data_byte", m_axis_tdata[7:0], want.data_byte);
      if (m_axis_tdata[15:8] !== want.packet_type)
        report_mismatch("packet_type", m_axis_tdata[15:8], want.packet_type);
      if (m_axis_tdata[23:16] !== want.packet_counter)
        report_mismatch("packet_counter", m_axis_tdata[23:16], want.packet_counter);
      if (m_axis_tdata[39:24] !== want.payload_length)
        report_mismatch("payload_length", m_axis_tdata[39:24], want.payload_length);
      if (m_axis_tlast !== want.last) report_mismatch("last", m_axis_tlast, want.last);
    end
  endtask

  // monitor: results are checked before the item of this edge is predicted
  always @(posedge clk) begin
    if (rst) begin
      fr_state = ST_HUNT_FIRST;
      hdr_idx = 2'd0;
      hdr_type = 8'h00;
      hdr_counter = 8'h00;
      hdr_length = 16'h0000;
      payload_count = 16'h0000;
      run_a = 8'h00;
      run_b = 8'h00;
      check_msb = 8'h00;
      cfg_max_length = MAX_LENGTH_RESET;
      cfg_check_enable = 1'b1;
      expected_results.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (s_axis_tvalid && s_axis_tready) begin
        deframe_byte(s_axis_tdata);
        bytes_accepted++;
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_MAX_LENGTH) cfg_max_length = pwdata[15:0];
        else cfg_check_enable = pwdata[0];
      end
    end
    byte_taken <= s_axis_tvalid && s_axis_tready;
  end

  // driver: next item goes out once the current one has been taken
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= 8'h00;
    end else if (!s_axis_tvalid || byte_taken) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pending_bytes.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(input logic [15:0] max_len, input logic chk_en);
    write_reg(REG_MAX_LENGTH, {16'h0000, max_len});
    write_reg(REG_CHECK_ENABLE, {31'd0, chk_en});
    stim_max_length = max_len;
    settings_used++;
  endtask

  // wait until every item is taken and every result is in, then let the pipe settle
  task automatic drain();
    while (pending_bytes.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic add_byte(input logic [7:0] b);
    pending_bytes = {pending_bytes, b};
  endtask

  // whole packet with a correct or damaged check; stops after the header when oversize
  task automatic queue_packet(input logic [7:0] ptype, input logic [7:0] pcount,
                              input logic [15:0] plen, input bit corrupt);
    logic [7:0]  a;
    logic [7:0]  bsum;
    logic [7:0]  pb;
    logic [7:0]  hdr[4];
    logic [15:0] chk;
    a = 8'h00;
    bsum = 8'h00;
    hdr = '{ptype, pcount, plen[15:8], plen[7:0]};
    add_byte(START_FIRST);
    add_byte(START_SECOND);
    foreach (hdr[i]) begin
      add_byte(hdr[i]);
      a = a + hdr[i];
      bsum = bsum + a;
    end
    if (plen > stim_max_length) return;
    for (int i = 0; i < plen; i++) begin
      pb = 8'($urandom);
      add_byte(pb);
      a = a + pb;
      bsum = bsum + a;
    end
    chk = {a, bsum};
    if (corrupt) chk = chk ^ (16'd1 << $urandom_range(15));
    add_byte(chk[15:8]);
    add_byte(chk[7:0]);
  endtask

  task automatic queue_stream(input int n);
    int          base;
    int          r;
    logic [15:0] plen;
    logic [7:0]  b;
    base = pending_bytes.size();
    while (pending_bytes.size() - base < n) begin
      r = $urandom_range(99);
      if (r < 65) begin
        plen = ($urandom_range(19) == 0) ? 16'($urandom_range(120, 40))
                                         : 16'($urandom_range(12, 0));
        queue_packet(8'($urandom), 8'($urandom), plen, $urandom_range(3) == 0);
      end else if (r < 77 && stim_max_length != 16'hFFFF) begin
        plen = 16'($urandom_range(32'hFFFF, stim_max_length + 32'd1));
        queue_packet(8'($urandom), 8'($urandom), plen, 1'b0);
      end else if (r < 88) begin
        repeat ($urandom_range(4, 1)) add_byte(8'($urandom));
      end else begin
        // near miss on the start bytes
        b = 8'($urandom);
        if (b == START_SECOND) b = START_FIRST;
        add_byte(START_FIRST);
        add_byte(b);
      end
    end
  endtask

  initial begin
    stim_max_length = MAX_LENGTH_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // noise, a swallowed repeat of the first start byte, a wrong second byte
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(START_FIRST);
    add_byte(START_FIRST);
    add_byte(START_SECOND);
    add_byte(START_FIRST);
    add_byte(8'h41);
    queue_packet(8'hFF, 8'h00, 16'd0, 1'b0);
    queue_packet(8'h00, 8'hFF, 16'd2, 1'b1);
    queue_packet(8'hA5, 8'h5A, MAX_LENGTH_RESET + 16'd1, 1'b0);
    queue_packet(8'h12, 8'h34, 16'hFFFF, 1'b0);
    drain();

    // check off: a damaged zero-length packet still ends good
    set_config(16'd0, 1'b0);
    queue_packet(8'h3C, 8'hC3, 16'd0, 1'b1);
    queue_packet(8'h81, 8'h18, 16'd1, 1'b0);
    drain();

    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 45; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 45; end
        default: begin send_idle_pct = 24; stall_pct = 24; end
      endcase
      for (int s = 0; s < 2; s++) begin
        case (mode * 2 + s)
          0: set_config(16'hFFFF, 1'b1);
          1: set_config(16'd5, 1'b1);
          2: set_config(16'($urandom_range(64, 0)), 1'b0);
          3: set_config(16'd0, 1'b1);
          4: set_config(16'($urandom_range(64, 0)), 1'($urandom_range(1)));
          5: set_config(16'hFFFF, 1'b0);
          6: set_config(MAX_LENGTH_RESET, 1'b1);
          default: set_config(16'($urandom), 1'b1);
        endcase
        queue_stream(225);
        drain();
      end
    end

    if (expected_results.size() != 0)
      report_mismatch("results never delivered", expected_results.size(), 0);
    $display("%0d bytes sent under %0d register settings, %0d payload bytes checked",
             bytes_accepted, settings_used, n_payload);
    $display("packet ends: %0d good, %0d failed check, %0d headers rejected",
             n_good, n_bad, n_rejected);
    if (errors == 0) begin
      $display("[sync_word_packet_deframer] OK");
    end else begin
      $display("[sync_word_packet_deframer] ERROR");
    end
    $finish;
  end

  initial begin
    #3_200_000;
    $display("[sync_word_packet_deframer] ERROR");
    $finish;
  end

endmodule
